// File: rtl/abe_pkg.sv
package abe_pkg;

  // axis layout: sticks first, then triggers
  localparam int unsigned STICK_AXES   = 4;
  localparam int unsigned AXIS_COUNT   = 6;
  localparam int unsigned TRIGGER_BASE = 2 * (STICK_AXES - 1) + 2;

  localparam int unsigned BIND_W  = 5;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned LEVEL_W = 15;
  localparam int unsigned DIFF_W  = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_PRESS_THRESHOLD    = 2'd0;
  localparam logic [1:0] CFG_RELEASE_DIFFERENCE = 2'd1;
  localparam logic [1:0] CFG_TRIGGER_DEAD_LEVEL = 2'd2;

  localparam logic [LEVEL_W-1:0] PRESS_THRESHOLD_RST    = 15'd16384;
  localparam logic [DIFF_W-1:0]  RELEASE_DIFFERENCE_RST = 16'd8192;
  localparam logic [LEVEL_W-1:0] TRIGGER_DEAD_LEVEL_RST = 15'd8000;

  // event kinds
  localparam logic FUNC_BUTTON = 1'b0;
  localparam logic FUNC_AXIS   = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [4:0]               event_index;
    logic                     pressed;
    logic signed [AXIS_W-1:0] axis_value;
  } in_word_t;

  typedef struct packed {
    logic [BIND_W-1:0] bind_number;
    logic              is_press;
    logic              last;
  } out_word_t;

  // results of one input word, up to two
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } result_pair_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] press_threshold;
    logic [DIFF_W-1:0]  release_difference;
    logic [LEVEL_W-1:0] trigger_dead_level;
  } cfg_t;

endpackage

// File: rtl/abe_core.sv
module abe_core #(
  parameter int unsigned BUTTON_COUNT = 21
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  abe_pkg::in_word_t  in_data_i,
  input  abe_pkg::cfg_t      cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output abe_pkg::out_word_t out_data_o
);

  abe_pkg::in_word_t     s1_q;
  logic                  s1_valid_q;
  abe_pkg::result_pair_t res;
  logic [1:0]            q_count;
  logic                  fire;

  // input register; the word leaves it once all its results fit in the buffer
  assign fire       = s1_valid_q && ((3'(q_count) + 3'(res.count)) <= 3'd2);
  assign in_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_q <= in_data_i;
  end

  abe_event_core #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_event (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .word_i  (s1_q),
    .commit_i(fire),
    .cfg_i   (cfg_i),
    .res_o   (res)
  );

  abe_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res),
    .push_en_i  (fire),
    .count_o    (q_count),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/abe_out_queue.sv
module abe_out_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  abe_pkg::result_pair_t push_i,
  input  logic                  push_en_i,
  output logic [1:0]            count_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output abe_pkg::out_word_t    out_data_o
);

  abe_pkg::out_word_t ent_q [2];
  abe_pkg::out_word_t ent_d [2];
  logic [1:0]         count_q, count_d, cnt;
  logic               pop;

  assign pop         = (count_q != 2'd0) && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = ent_q[0];
  assign count_o     = count_q;

  always_comb begin
    ent_d = ent_q;
    cnt   = count_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
      cnt      = count_q - 2'd1;
    end
    count_d = cnt;
    if (push_en_i) begin
      // room is checked upstream, so cnt is 0 or 1 here when anything is pushed
      if (push_i.count == 2'd2) begin
        ent_d[0] = push_i.first;
        ent_d[1] = push_i.second;
      end else if (push_i.count == 2'd1) begin
        ent_d[cnt[0]] = push_i.first;
      end
      count_d = cnt + push_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// File: rtl/abe_event_core.sv
module abe_event_core #(
  parameter int unsigned BUTTON_COUNT = 21
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  abe_pkg::in_word_t     word_i,
  input  logic                  commit_i,
  input  abe_pkg::cfg_t         cfg_i,
  output abe_pkg::result_pair_t res_o
);

  localparam int unsigned AW = abe_pkg::AXIS_W;
  localparam int unsigned BW = abe_pkg::BIND_W;
  localparam logic [BW-1:0] BIND_BASE = BW'(BUTTON_COUNT);
  localparam logic [BW-1:0] TRIG_BASE = BW'(BUTTON_COUNT + abe_pkg::TRIGGER_BASE);

  logic [abe_pkg::AXIS_COUNT-1:0] active_q, active_d;
  logic signed [AW-1:0]           cap_q [abe_pkg::STICK_AXES];
  logic signed [AW-1:0]           cap_d [abe_pkg::STICK_AXES];

  logic                 is_stick, is_trig;
  logic [1:0]           stick;
  logic signed [AW-1:0] v, cap_sel;
  logic signed [AW:0]   diff;
  logic [AW:0]          diff_mag, val_mag;
  logic                 act;
  logic                 rel, prs;
  logic [BW-1:0]        rel_bind, prs_bind;
  abe_pkg::out_word_t   w_rel, w_prs;

  assign v        = word_i.axis_value;
  assign is_stick = (word_i.func == abe_pkg::FUNC_AXIS) &&
                    (word_i.event_index < 5'(abe_pkg::STICK_AXES));
  assign is_trig  = (word_i.func == abe_pkg::FUNC_AXIS) &&
                    (word_i.event_index >= 5'(abe_pkg::STICK_AXES)) &&
                    (word_i.event_index < 5'(abe_pkg::AXIS_COUNT));
  assign stick    = word_i.event_index[1:0];
  assign cap_sel  = cap_q[stick];
  assign act      = active_q[word_i.event_index[2:0]];

  // distance from the captured value and magnitude of the new one
  assign diff     = (AW+1)'(v) - (AW+1)'(cap_sel);
  assign diff_mag = diff[AW] ? (AW+1)'(-diff) : diff;
  assign val_mag  = v[AW-1] ? (AW+1)'(-((AW+1)'(v))) : (AW+1)'(v);

  always_comb begin
    rel = 1'b0;
    prs = 1'b0;
    if (is_stick) begin
      rel = act && (diff_mag >= (AW+1)'(cfg_i.release_difference));
      prs = (!act || rel) && (val_mag >= (AW+1)'(cfg_i.press_threshold));
    end else if (is_trig) begin
      prs = !act && (v >= $signed({1'b0, cfg_i.press_threshold}));
      rel = act && (v <= $signed({1'b0, cfg_i.trigger_dead_level}));
    end
  end

  // stick release follows the sign of the captured value
  always_comb begin
    if (is_trig) begin
      rel_bind = TRIG_BASE + BW'(word_i.event_index[0]);
      prs_bind = rel_bind;
    end else begin
      rel_bind = BIND_BASE + BW'({stick, ~cap_sel[AW-1]});
      prs_bind = BIND_BASE + BW'({stick, ~v[AW-1]});
    end
  end

  always_comb begin
    w_rel = '{bind_number: rel_bind, is_press: 1'b0, last: !prs};
    w_prs = '{bind_number: prs_bind, is_press: 1'b1, last: 1'b1};
    res_o = '0;
    if (word_i.func == abe_pkg::FUNC_BUTTON) begin
      res_o.count = 2'd1;
      res_o.first = '{bind_number: word_i.event_index, is_press: word_i.pressed,
                      last: 1'b1};
    end else begin
      res_o.count = 2'(rel) + 2'(prs);
      if (rel) begin
        res_o.first  = w_rel;
        res_o.second = w_prs;
      end else begin
        res_o.first = w_prs;
      end
    end
  end

  always_comb begin
    active_d = active_q;
    cap_d    = cap_q;
    if (commit_i && (is_stick || is_trig)) begin
      if (prs) begin
        active_d[word_i.event_index[2:0]] = 1'b1;
        if (is_stick) cap_d[stick] = v;
      end else if (rel) begin
        active_d[word_i.event_index[2:0]] = 1'b0;
        if (is_stick) cap_d[stick] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < abe_pkg::STICK_AXES; i++) cap_q[i] <= '0;
    end else begin
      active_q <= active_d;
      cap_q    <= cap_d;
    end
  end

endmodule

// File: rtl/axis_hysteresis_bind_events.sv
// Gamepad event to bind event translator. A button word passes through as one
// press or release of its own bind number; an axis word updates that axis's
// hysteresis record. Sticks (axes 0 to 3) release once they move at least
// release_difference from the captured value, on the side that was pressed,
// and then press when their magnitude reaches press_threshold, so one word may
// give a release followed by a press. Triggers (axes 4 and 5) press at
// press_threshold and release at or below trigger_dead_level. Axis numbers
// above 5 give no result. The last flag marks the final result of each word.
// Rate, while the receiver is ready: one word per cycle if each word gives at
// most one result; a word giving two results holds the input stage until the
// two-entry result buffer, draining one result per cycle, is empty. A word is
// held in the input register, its results in the buffer. Configuration writes
// are always accepted and should only be made while the block is idle.
module axis_hysteresis_bind_events #(
  parameter int unsigned BUTTON_COUNT = 21
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // event words in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  abe_pkg::in_word_t  in_data_i,
  // bind words out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output abe_pkg::out_word_t out_data_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  abe_pkg::cfg_t cfg_q;

  // config registers, written one at a time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_threshold    <= abe_pkg::PRESS_THRESHOLD_RST;
      cfg_q.release_difference <= abe_pkg::RELEASE_DIFFERENCE_RST;
      cfg_q.trigger_dead_level <= abe_pkg::TRIGGER_DEAD_LEVEL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        abe_pkg::CFG_PRESS_THRESHOLD:    cfg_q.press_threshold    <= cfg_data_i[14:0];
        abe_pkg::CFG_RELEASE_DIFFERENCE: cfg_q.release_difference <= cfg_data_i;
        abe_pkg::CFG_TRIGGER_DEAD_LEVEL: cfg_q.trigger_dead_level <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // input register, per-axis hysteresis and two-entry result buffer
  abe_core #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: bench/bind_event_checker.sv
`timescale 1ns / 1ps
module bind_event_checker #(
  parameter int unsigned BUTTON_COUNT = 21
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  abe_pkg::in_word_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  abe_pkg::out_word_t out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 binds_pending_o
);

  localparam int BW = abe_pkg::BIND_W;

  logic [abe_pkg::LEVEL_W-1:0]       press_level;
  logic [abe_pkg::DIFF_W-1:0]        release_span;
  logic [abe_pkg::LEVEL_W-1:0]       dead_level;
  logic                              axis_on   [abe_pkg::AXIS_COUNT];
  logic signed [abe_pkg::AXIS_W-1:0] axis_held [abe_pkg::AXIS_COUNT];

  // bind words still owed by the block, oldest first
  abe_pkg::out_word_t binds_due [$];

  function automatic logic [BW-1:0] stick_bind_no(int axis, bit negative);
    return BW'(BUTTON_COUNT + 2 * axis + (negative ? 0 : 1));
  endfunction

  task automatic predict_binds(input abe_pkg::in_word_t w);
    abe_pkg::out_word_t res [2];
    int                 n;
    int                 a;
    int                 v;
    int                 travel;
    logic [BW-1:0]      trig_no;
    n = 0;
    a = int'(w.event_index);
    v = int'($signed(w.axis_value));
    if (w.func == abe_pkg::FUNC_BUTTON) begin
      res[0] = '{w.event_index, w.pressed, 1'b0};
      n = 1;
    end else if (a < abe_pkg::AXIS_COUNT) begin
      if (a < abe_pkg::STICK_AXES) begin
        travel = v - int'(axis_held[a]);
        if (travel < 0) travel = -travel;
        // release on the side that was captured, not the side now held
        if (axis_on[a] && travel >= int'(release_span)) begin
          res[n] = '{stick_bind_no(a, axis_held[a] < 0), 1'b0, 1'b0};
          n++;
          axis_on[a]   = 1'b0;
          axis_held[a] = '0;
        end
        if (!axis_on[a] && (v < 0 ? -v : v) >= int'(press_level)) begin
          axis_on[a]   = 1'b1;
          axis_held[a] = w.axis_value;
          res[n] = '{stick_bind_no(a, v < 0), 1'b1, 1'b0};
          n++;
        end
      end else begin
        trig_no = BW'(BUTTON_COUNT + abe_pkg::TRIGGER_BASE + (a - abe_pkg::STICK_AXES));
        if (!axis_on[a] && v >= int'(press_level)) begin
          axis_on[a]   = 1'b1;
          axis_held[a] = w.axis_value;
          res[n] = '{trig_no, 1'b1, 1'b0};
          n++;
        end else if (axis_on[a] && v <= int'(dead_level)) begin
          axis_on[a]   = 1'b0;
          axis_held[a] = '0;
          res[n] = '{trig_no, 1'b0, 1'b0};
          n++;
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) binds_due.push_back(res[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    abe_pkg::out_word_t due;
    if (!rst_ni) begin
      press_level  = abe_pkg::PRESS_THRESHOLD_RST;
      release_span = abe_pkg::RELEASE_DIFFERENCE_RST;
      dead_level   = abe_pkg::TRIGGER_DEAD_LEVEL_RST;
      for (int i = 0; i < abe_pkg::AXIS_COUNT; i++) begin
        axis_on[i]   = 1'b0;
        axis_held[i] = '0;
      end
      binds_due.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (binds_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected bind word: bind %0d press %0b last %0b", $realtime,
                     out_data_i.bind_number, out_data_i.is_press, out_data_i.last);
        end else begin
          due = binds_due.pop_front();
          if (out_data_i.bind_number !== due.bind_number ||
              out_data_i.is_press !== due.is_press || out_data_i.last !== due.last) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: bind word mismatch: expected bind %0d press %0b last %0b,",
                        " got %0d %0b %0b"},
                       $realtime, due.bind_number, due.is_press, due.last,
                       out_data_i.bind_number, out_data_i.is_press, out_data_i.last);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          abe_pkg::CFG_PRESS_THRESHOLD:
            press_level  = cfg_data_i[abe_pkg::LEVEL_W-1:0];
          abe_pkg::CFG_RELEASE_DIFFERENCE:
            release_span = cfg_data_i[abe_pkg::DIFF_W-1:0];
          abe_pkg::CFG_TRIGGER_DEAD_LEVEL:
            dead_level   = cfg_data_i[abe_pkg::LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_binds(in_data_i);
    end
    binds_pending_o = binds_due.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int unsigned BUTTON_COUNT  = 21;
  // generous ceiling: every word two results, slow receiver, long hold-off
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned HOLD_CYCLES   = 400;
  // let the block settle before touching registers
  localparam int unsigned SETTLE_CYCLES = 8;
  // index with no register behind it, writes there must change nothing
  localparam logic [1:0]  CFG_SPARE     = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  abe_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  abe_pkg::out_word_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  int fail_count;
  int binds_pending;
  int cycles = 0;

  // idling odds per cycle, and the long receiver hold-off
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_rx = 1'b0;
  bit flood_phase = 1'b0;

  // levels as last written, only used to aim the random values
  int press_lvl;
  int diff_lvl;
  int dead_lvl;
  int axis_last [abe_pkg::AXIS_COUNT];

  axis_hysteresis_bind_events #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  bind_event_checker #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .binds_pending_o(binds_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: ready decided afresh at every falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long back-pressure once the sender runs flat out, so the block fills and
  // has to stall its input
  initial begin
    wait (flood_phase);
    repeat ($urandom_range(60, 20)) @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  function automatic abe_pkg::in_word_t ev(logic f, logic [4:0] idx, logic pr, int v);
    abe_pkg::in_word_t w;
    w.func        = f;
    w.event_index = idx;
    w.pressed     = pr;
    w.axis_value  = 16'(v);
    return w;
  endfunction

  function automatic int jitter();
    return int'($urandom_range(4)) - 2;
  endfunction

  function automatic int rail_value();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      3:       return 1;
      default: return 0;
    endcase
  endfunction

  // one event word; called at a falling edge, returns at the falling edge
  // after acceptance with valid still high
  task automatic send_event(input abe_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // only ever called with the block drained
  task automatic set_levels(input logic [15:0] press, input logic [15:0] diff,
                            input logic [15:0] dead, input bit with_spare);
    if (with_spare) write_reg(CFG_SPARE, 16'($urandom));
    write_reg(abe_pkg::CFG_PRESS_THRESHOLD, press);
    write_reg(abe_pkg::CFG_RELEASE_DIFFERENCE, diff);
    write_reg(abe_pkg::CFG_TRIGGER_DEAD_LEVEL, dead);
    cfg_valid <= 1'b0;
    press_lvl = int'(press[abe_pkg::LEVEL_W-1:0]);
    diff_lvl  = int'(diff);
    dead_lvl  = int'(dead[abe_pkg::LEVEL_W-1:0]);
  endtask

  // stop sending, wait for every owed bind word, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (binds_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly axis motion aimed at the thresholds, some buttons, a little noise
  task automatic random_event(output abe_pkg::in_word_t w);
    int roll;
    int a;
    int v;
    int s;
    roll          = $urandom_range(99);
    w.func        = abe_pkg::FUNC_AXIS;
    w.pressed     = 1'($urandom_range(1));
    w.axis_value  = 16'($urandom);
    w.event_index = '0;
    if (roll < 15) begin
      w.func        = abe_pkg::FUNC_BUTTON;
      w.event_index = 5'($urandom_range(31));
    end else if (roll < 20) begin
      // axis numbers the block must ignore
      w.event_index = 5'($urandom_range(31, abe_pkg::AXIS_COUNT));
    end else begin
      a = $urandom_range(abe_pkg::AXIS_COUNT - 1);
      s = $urandom_range(1) ? 1 : -1;
      v = int'($signed(w.axis_value));
      if (a < abe_pkg::STICK_AXES) begin
        case ($urandom_range(9))
          0:       ;
          1:       v = s * (press_lvl + jitter());
          2:       v = axis_last[a] + s * (diff_lvl + jitter());
          3:       v = rail_value();
          4, 5:    v = axis_last[a] + int'($urandom_range(4000)) - 2000;
          6:       v = 0;
          default: v = s * (press_lvl + int'($urandom_range(32767 - press_lvl)));
        endcase
      end else begin
        case ($urandom_range(9))
          0:       ;
          1:       v = press_lvl + jitter();
          2:       v = dead_lvl + jitter();
          3:       v = rail_value();
          4, 5:    v = press_lvl + int'($urandom_range(32767 - press_lvl));
          6, 7:    v = dead_lvl - int'($urandom_range(dead_lvl + 32768));
          default: v = axis_last[a] + int'($urandom_range(4000)) - 2000;
        endcase
      end
      w.event_index = 5'(a);
      w.axis_value  = 16'(v);
      axis_last[a]  = int'($signed(w.axis_value));
    end
  endtask

  // ignored axis words go through but do not count
  task automatic run_random(input int n, input int send_pct, input int recv_pct);
    abe_pkg::in_word_t w;
    int                counted;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    counted = 0;
    while (counted < n) begin
      random_event(w);
      send_event(w);
      if (!(w.func == abe_pkg::FUNC_AXIS && w.event_index >= abe_pkg::AXIS_COUNT)) counted++;
    end
    drain();
  endtask

  initial begin
    logic [14:0] p;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = abe_pkg::CFG_PRESS_THRESHOLD;
    cfg_data  = '0;
    send_idle_pct = 13;
    recv_idle_pct = 82;
    press_lvl = int'(abe_pkg::PRESS_THRESHOLD_RST);
    diff_lvl  = int'(abe_pkg::RELEASE_DIFFERENCE_RST);
    dead_lvl  = int'(abe_pkg::TRIGGER_DEAD_LEVEL_RST);
    for (int i = 0; i < abe_pkg::AXIS_COUNT; i++) axis_last[i] = 0;

    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed words at reset levels: press 16384, release span 8192, dead 8000
    send_event(ev(abe_pkg::FUNC_BUTTON, 5'd0,  1'b1, 0));
    send_event(ev(abe_pkg::FUNC_BUTTON, 5'd20, 1'b0, -1));
    // button numbers past the button count pass straight through
    send_event(ev(abe_pkg::FUNC_BUTTON, 5'd21, 1'b1, 32767));
    send_event(ev(abe_pkg::FUNC_BUTTON, 5'd31, 1'b1, -32768));
    // stick 0: press exactly at level, too small a move, release, then
    // opposite rail gives release followed by press in one word
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd0, 1'b1, 16384));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd0, 1'b0, 16383));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd0, 1'b0, 8192));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd0, 1'b1, -32768));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd0, 1'b0, 32767));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd0, 1'b0, 0));
    // stick 1: release crosses zero, must drop the positive side bind
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd1, 1'b0, 16384));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd1, 1'b0, -100));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd2, 1'b0, -16384));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd2, 1'b1, -16383));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd3, 1'b0, 32767));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd3, 1'b0, -32768));
    // triggers: just below and at press level, just above and at dead level
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd4, 1'b0, 16383));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd4, 1'b0, 16384));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd4, 1'b0, 8001));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd4, 1'b0, 8000));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd5, 1'b1, 32767));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd5, 1'b0, -32768));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd5, 1'b0, -32768));
    // axis numbers above the triggers give nothing
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd6,  1'b0, 32767));
    send_event(ev(abe_pkg::FUNC_AXIS, 5'd31, 1'b1, -32768));
    drain();

    // slow receiver, quick sender
    run_random(320, 13, 82);

    // bottom levels: once pressed, every stick word releases and presses again
    set_levels(16'd0, 16'd0, 16'd0, 1'b0);
    run_random(250, 13, 82);

    // top levels, top bit of the press write must be dropped; spare index too
    set_levels(16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b1);
    run_random(250, 82, 13);

    // mid levels, slow sender, quick receiver
    p = 15'($urandom_range(30000, 1000));
    set_levels({1'($urandom_range(1)), p}, 16'($urandom_range(60000, 1000)),
               16'($urandom_range(p)), 1'b0);
    run_random(330, 82, 13);

    // no idling on either side, with the long hold-off somewhere inside
    p = 15'($urandom_range(28000, 4000));
    set_levels({1'b0, p}, 16'($urandom_range(40000, 500)), 16'($urandom_range(p)), 1'b0);
    flood_phase = 1'b1;
    run_random(400, 0, 0);

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
